>>> rtl/i2cm_pkg.sv
package i2cm_pkg;

  // Operation codes carried by the op field of an input word.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_PUSH  = 2'd3;

  // Default depth of the write byte queue.
  localparam int FIFO_DEPTH_DEF = 16;

endpackage

>>> rtl/i2cm_fifo.sv
module i2cm_fifo import i2cm_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] wdata,
  input  logic       pop,
  output logic [7:0] rdata,
  output logic       empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [FW-1:0] fill;
  logic          push_ok;
  logic          pop_ok;

  // A push into a full queue is dropped.
  assign push_ok = push && (fill != FW'(DEPTH));
  assign pop_ok  = pop && (fill != '0);
  assign empty   = (fill == '0);

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail] <= wdata;
    end
    if (pop_ok) begin
      rdata <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (push_ok) begin
        tail <= (tail == AW'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop_ok) begin
        head <= (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        fill <= fill + 1'b1;
      end else if (pop_ok && !push_ok) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> rtl/i2c_master_register_access_top.sv
// I2C master for register reads and writes, stepped one bus timing step per tick.
// Input channel (in_valid/in_ready): each word carries an op. A tick advances the
// bus sequencer by one step and samples sda_in; begin read and begin write latch
// target_reg and byte_count when the master is idle; a push appends
// write_byte to the write queue (dropped when the queue is full).
// Output channel (out_valid/out_ready): exactly one result word per input word,
// giving the SCL/SDA drive levels, a completed read byte, a slave NACK flag, and
// busy and done status.
// Configuration: cfg_wen with cfg_wdata loads the seven-bit device address.
// The result of a word accepted at one edge is presented in the cycle after it.
// One word can be accepted every cycle while the receiver keeps up; the sequencer
// state and the result register are updated together at the accepting edge.
// The write queue is a memory with a registered read port; a data byte is read
// on its setup step and moved into the shift register on the following step.
// When the receiver stalls, the result register holds its word and in_ready
// drops until it is taken; in_ready is high whenever the register is empty or
// being emptied in the same cycle.
// Reset clears the sequencer to idle, empties the queue, sets the held bus lines
// to SCL high, SDA high and driven, clears the address, and empties the output.
module i2c_master_register_access_top import i2cm_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  target_reg,
  input  logic [15:0] byte_count,
  input  logic [7:0]  write_byte,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        scl_level,
  output logic        sda_level,
  output logic        sda_driving,
  output logic [7:0]  read_byte,
  output logic        read_valid,
  output logic        nack_seen,
  output logic        busy_res,
  output logic        done_res
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_START, PH_TX_AW, PH_ACK_AW, PH_TX_REG, PH_ACK_REG, PH_RSTART,
    PH_TX_AR, PH_ACK_AR, PH_RX, PH_MACK, PH_TX_DATA, PH_ACK_DATA, PH_STOP
  } phase_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } lines_t;

  // SDA reads as high whenever the master has released it.
  function automatic lines_t drive(logic scl, logic sda, logic drv);
    lines_t l;
    l.scl = scl;
    l.drv = drv;
    l.sda = drv ? sda : 1'b1;
    return l;
  endfunction

  phase_t      phase, phase_next;
  logic [1:0]  step, step_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic        is_read, is_read_next;
  logic [7:0]  reg_addr_hold, reg_addr_hold_next;
  logic        load_pend, load_pend_next;
  lines_t      lines, lines_next;
  logic [6:0]  slave_addr;

  logic        accept;
  logic        rv, nack, done;
  logic        pop;
  logic        fifo_empty;
  logic [7:0]  fifo_rdata;
  logic [7:0]  tx_byte;
  logic        last_ack;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  i2cm_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (accept && (op == OP_PUSH)),
    .wdata (write_byte),
    .pop   (accept && pop),
    .rdata (fifo_rdata),
    .empty (fifo_empty)
  );

  // The byte to shift out: fresh queue data on the step after its read.
  assign tx_byte  = load_pend ? fifo_rdata : shift_byte;
  // After a read byte, the master acknowledges unless it was the last one.
  assign last_ack = (bytes_left == '0);

  always_comb begin
    phase_next         = phase;
    step_next          = step;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    bytes_left_next    = bytes_left;
    is_read_next       = is_read;
    reg_addr_hold_next = reg_addr_hold;
    load_pend_next     = load_pend;
    lines_next         = lines;
    rv                 = 1'b0;
    nack               = 1'b0;
    done               = 1'b0;
    pop                = 1'b0;

    case (op)
      OP_READ, OP_WRITE: begin
        if (phase == PH_IDLE) begin
          reg_addr_hold_next = target_reg;
          bytes_left_next    = byte_count;
          is_read_next       = (op == OP_READ);
          phase_next         = PH_START;
          step_next          = '0;
          bit_index_next     = '0;
        end
      end
      OP_TICK: begin
        case (phase)
          PH_IDLE: begin
          end
          PH_START, PH_RSTART: begin
            if (step == 2'd0) begin
              lines_next = drive(1'b1, 1'b1, 1'b1);
              step_next  = 2'd1;
            end else if (step == 2'd1) begin
              lines_next = drive(1'b1, 1'b0, 1'b1);
              step_next  = 2'd2;
            end else begin
              lines_next     = drive(1'b0, 1'b0, 1'b1);
              phase_next     = (phase == PH_START) ? PH_TX_AW : PH_TX_AR;
              step_next      = '0;
              bit_index_next = '0;
            end
          end
          PH_TX_AW, PH_TX_REG, PH_TX_AR, PH_TX_DATA: begin
            if (step == 2'd0) begin
              lines_next = drive(1'b0, 1'b0, 1'b1);
              // With no queued data the setup step repeats and SCL stays low.
              if (!(phase == PH_TX_DATA && fifo_empty)) begin
                case (phase)
                  PH_TX_AW:  shift_byte_next = {slave_addr, 1'b0};
                  PH_TX_AR:  shift_byte_next = {slave_addr, 1'b1};
                  PH_TX_REG: shift_byte_next = reg_addr_hold;
                  default: begin
                    pop             = 1'b1;
                    load_pend_next  = 1'b1;
                    bytes_left_next = bytes_left - 16'd1;
                  end
                endcase
                bit_index_next = '0;
                step_next      = 2'd1;
              end
            end else if (step == 2'd1) begin
              shift_byte_next = tx_byte;
              load_pend_next  = 1'b0;
              lines_next      = drive(1'b0, tx_byte[7], 1'b1);
              step_next       = 2'd2;
            end else begin
              lines_next      = drive(1'b1, shift_byte[7], 1'b1);
              shift_byte_next = {shift_byte[6:0], 1'b0};
              if (bit_index == 3'd7) begin
                case (phase)
                  PH_TX_AW:  phase_next = PH_ACK_AW;
                  PH_TX_REG: phase_next = PH_ACK_REG;
                  PH_TX_AR:  phase_next = PH_ACK_AR;
                  default:   phase_next = PH_ACK_DATA;
                endcase
                step_next      = '0;
                bit_index_next = '0;
              end else begin
                bit_index_next = bit_index + 3'd1;
                step_next      = 2'd1;
              end
            end
          end
          PH_ACK_AW, PH_ACK_REG, PH_ACK_AR, PH_ACK_DATA: begin
            if (step == 2'd0) begin
              lines_next = drive(1'b1, 1'b1, 1'b0);
              nack       = sda_in;
              step_next  = 2'd1;
            end else begin
              lines_next     = drive(1'b0, 1'b1, 1'b0);
              step_next      = '0;
              bit_index_next = '0;
              case (phase)
                PH_ACK_AW: phase_next = PH_TX_REG;
                PH_ACK_REG: begin
                  if (is_read) begin
                    phase_next = PH_RSTART;
                  end else begin
                    phase_next = last_ack ? PH_STOP : PH_TX_DATA;
                  end
                end
                PH_ACK_AR: phase_next = last_ack ? PH_MACK : PH_RX;
                default:   phase_next = last_ack ? PH_STOP : PH_TX_DATA;
              endcase
            end
          end
          PH_RX: begin
            if (step == 2'd0) begin
              lines_next     = drive(1'b0, 1'b1, 1'b0);
              bit_index_next = '0;
              step_next      = 2'd1;
            end else if (step == 2'd1) begin
              lines_next      = drive(1'b1, 1'b1, 1'b0);
              shift_byte_next = {shift_byte[6:0], sda_in};
              rv              = (bit_index == 3'd7);
              step_next       = 2'd2;
            end else begin
              lines_next = drive(1'b0, 1'b1, 1'b0);
              if (bit_index == 3'd7) begin
                bytes_left_next = bytes_left - 16'd1;
                phase_next      = PH_MACK;
                step_next       = '0;
                bit_index_next  = '0;
              end else begin
                bit_index_next = bit_index + 3'd1;
                step_next      = 2'd1;
              end
            end
          end
          PH_MACK: begin
            if (step == 2'd0) begin
              lines_next = drive(1'b0, 1'b0, 1'b1);
              step_next  = 2'd1;
            end else if (step == 2'd1) begin
              lines_next = drive(1'b0, last_ack, 1'b1);
              step_next  = 2'd2;
            end else if (step == 2'd2) begin
              lines_next = drive(1'b1, last_ack, 1'b1);
              step_next  = 2'd3;
            end else begin
              lines_next     = drive(1'b0, last_ack, 1'b1);
              phase_next     = last_ack ? PH_STOP : PH_RX;
              step_next      = '0;
              bit_index_next = '0;
            end
          end
          PH_STOP: begin
            if (step == 2'd0) begin
              lines_next = drive(1'b0, 1'b0, 1'b1);
              step_next  = 2'd1;
            end else if (step == 2'd1) begin
              lines_next = drive(1'b1, 1'b0, 1'b1);
              step_next  = 2'd2;
            end else begin
              lines_next     = drive(1'b1, 1'b1, 1'b1);
              done           = 1'b1;
              phase_next     = PH_IDLE;
              step_next      = '0;
              bit_index_next = '0;
            end
          end
          default: begin
            phase_next     = PH_IDLE;
            step_next      = '0;
            bit_index_next = '0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      step           <= '0;
      bit_index      <= '0;
      shift_byte     <= '0;
      bytes_left     <= '0;
      is_read        <= 1'b0;
      reg_addr_hold  <= '0;
      load_pend      <= 1'b0;
      lines          <= drive(1'b1, 1'b1, 1'b1);
      slave_addr     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wen) begin
        slave_addr <= cfg_wdata;
      end
      if (accept) begin
        phase         <= phase_next;
        step          <= step_next;
        bit_index     <= bit_index_next;
        shift_byte    <= shift_byte_next;
        bytes_left    <= bytes_left_next;
        is_read       <= is_read_next;
        reg_addr_hold <= reg_addr_hold_next;
        load_pend     <= load_pend_next;
        lines         <= lines_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register; it loads only when a word is accepted.
  always_ff @(posedge clk) begin
    if (accept) begin
      scl_level   <= lines_next.scl;
      sda_level   <= lines_next.sda;
      sda_driving <= lines_next.drv;
      read_byte   <= rv ? shift_byte_next : 8'd0;
      read_valid  <= rv;
      nack_seen   <= nack;
      busy_res    <= (phase_next != PH_IDLE);
      done_res    <= done;
    end
  end

`ifndef SYNTH
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  a_released_reads_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sda_driving |-> sda_level)
    else $error("released SDA not reported high");

  a_load_only_in_data: assert property (@(posedge clk) disable iff (rst)
    load_pend |-> (phase == PH_TX_DATA) && (step == 2'd1))
    else $error("queue byte pending outside a data byte");

  a_accept_gives_word: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");
`endif

endmodule

>>> tb/i2c_master_register_access_checker.sv
module i2c_master_register_access_checker import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  target_reg,
  input  logic [15:0] byte_count,
  input  logic [7:0]  write_byte,
  input  logic        sda_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        scl_level,
  input  logic        sda_level,
  input  logic        sda_driving,
  input  logic [7:0]  read_byte,
  input  logic        read_valid,
  input  logic        nack_seen,
  input  logic        busy_res,
  input  logic        done_res,
  output int          fail_count,
  output int          pending
);

  localparam int QDEPTH = FIFO_DEPTH_DEF;
  localparam int QAW = $clog2(QDEPTH);

  typedef enum logic [4:0] {
    BUS_IDLE, BUS_START, SEND_ADDR_W, ACK_ADDR_W, SEND_REG, ACK_REG, BUS_RESTART,
    SEND_ADDR_R, ACK_ADDR_R, RECV_BYTE, HOST_ACK, SEND_DATA, ACK_DATA, BUS_STOP
  } bus_phase_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drv;
    logic [7:0] rbyte;
    logic       rvalid;
    logic       nack;
    logic       busy;
    logic       fin;
  } line_report_t;

  logic [6:0]     dev_addr;
  bus_phase_t     ph;
  logic [2:0]     step;
  logic [3:0]     nbit;
  logic [7:0]     shreg;
  logic [15:0]    remaining;
  logic           reading;
  logic [7:0]     reg_hold;
  logic [7:0]     queue_mem [QDEPTH];
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   fill;
  logic           line_scl, line_sda, line_drv;

  line_report_t   awaited[$];
  line_report_t   got, want;
  int             errs;

  function automatic void set_lines(input logic scl, input logic sda, input logic drv);
    line_scl = scl;
    line_drv = drv;
    line_sda = drv ? sda : 1'b1;
  endfunction

  function automatic void enter(input bus_phase_t p);
    ph = p;
    step = 3'd0;
    nbit = 4'd0;
  endfunction

  function automatic void clear_model();
    dev_addr = 7'd0;
    enter(BUS_IDLE);
    shreg = 8'd0;
    remaining = 16'd0;
    reading = 1'b0;
    reg_hold = 8'd0;
    for (int k = 0; k < QDEPTH; k++) queue_mem[k] = 8'd0;
    rd_ptr = '0;
    fill = '0;
    set_lines(1'b1, 1'b1, 1'b1);
  endfunction

  // One bus timing step of a transaction in progress.
  function automatic void bus_step(input logic sda, output logic rv, output logic nack,
                                   output logic fin);
    logic ack_level;
    rv = 1'b0;
    nack = 1'b0;
    fin = 1'b0;
    ack_level = (remaining == 16'd0);
    case (ph)
      BUS_START, BUS_RESTART: begin
        if (step == 3'd0) begin
          set_lines(1'b1, 1'b1, 1'b1);
          step = 3'd1;
        end else if (step == 3'd1) begin
          set_lines(1'b1, 1'b0, 1'b1);
          step = 3'd2;
        end else begin
          set_lines(1'b0, 1'b0, 1'b1);
          if (ph == BUS_START) enter(SEND_ADDR_W);
          else enter(SEND_ADDR_R);
        end
      end
      SEND_ADDR_W, SEND_REG, SEND_ADDR_R, SEND_DATA: begin
        if (step == 3'd0) begin
          // With no data byte queued the setup step repeats, holding SCL low.
          if (ph == SEND_DATA && fill == '0) begin
            set_lines(1'b0, 1'b0, 1'b1);
          end else begin
            if (ph == SEND_ADDR_W) shreg = {dev_addr, 1'b0};
            else if (ph == SEND_ADDR_R) shreg = {dev_addr, 1'b1};
            else if (ph == SEND_REG) shreg = reg_hold;
            else begin
              shreg = queue_mem[rd_ptr];
              rd_ptr = rd_ptr + 1'b1;
              fill = fill - 1'b1;
              remaining = remaining - 1'b1;
            end
            set_lines(1'b0, 1'b0, 1'b1);
            nbit = 4'd0;
            step = 3'd1;
          end
        end else if (step == 3'd1) begin
          set_lines(1'b0, shreg[7], 1'b1);
          step = 3'd2;
        end else begin
          set_lines(1'b1, shreg[7], 1'b1);
          shreg = {shreg[6:0], 1'b0};
          nbit = nbit + 1'b1;
          if (nbit >= 4'd8) begin
            case (ph)
              SEND_ADDR_W: enter(ACK_ADDR_W);
              SEND_REG:    enter(ACK_REG);
              SEND_ADDR_R: enter(ACK_ADDR_R);
              default:     enter(ACK_DATA);
            endcase
          end else begin
            step = 3'd1;
          end
        end
      end
      ACK_ADDR_W, ACK_REG, ACK_ADDR_R, ACK_DATA: begin
        if (step == 3'd0) begin
          set_lines(1'b1, 1'b1, 1'b0);
          nack = sda;
          step = 3'd1;
        end else begin
          set_lines(1'b0, 1'b1, 1'b0);
          case (ph)
            ACK_ADDR_W: enter(SEND_REG);
            ACK_REG: begin
              if (reading) enter(BUS_RESTART);
              else if (remaining != 16'd0) enter(SEND_DATA);
              else enter(BUS_STOP);
            end
            ACK_ADDR_R: begin
              if (remaining != 16'd0) enter(RECV_BYTE);
              else enter(HOST_ACK);
            end
            default: begin
              if (remaining != 16'd0) enter(SEND_DATA);
              else enter(BUS_STOP);
            end
          endcase
        end
      end
      RECV_BYTE: begin
        if (step == 3'd0) begin
          set_lines(1'b0, 1'b1, 1'b0);
          nbit = 4'd0;
          step = 3'd1;
        end else if (step == 3'd1) begin
          set_lines(1'b1, 1'b1, 1'b0);
          shreg = {shreg[6:0], sda};
          if (nbit == 4'd7) rv = 1'b1;
          step = 3'd2;
        end else begin
          set_lines(1'b0, 1'b1, 1'b0);
          nbit = nbit + 1'b1;
          if (nbit >= 4'd8) begin
            remaining = remaining - 1'b1;
            enter(HOST_ACK);
          end else begin
            step = 3'd1;
          end
        end
      end
      HOST_ACK: begin
        // The master answers ACK while bytes remain and NACK after the last one.
        if (step == 3'd0) begin
          set_lines(1'b0, 1'b0, 1'b1);
          step = 3'd1;
        end else if (step == 3'd1) begin
          set_lines(1'b0, ack_level, 1'b1);
          step = 3'd2;
        end else if (step == 3'd2) begin
          set_lines(1'b1, ack_level, 1'b1);
          step = 3'd3;
        end else begin
          set_lines(1'b0, ack_level, 1'b1);
          if (remaining != 16'd0) enter(RECV_BYTE);
          else enter(BUS_STOP);
        end
      end
      BUS_STOP: begin
        if (step == 3'd0) begin
          set_lines(1'b0, 1'b0, 1'b1);
          step = 3'd1;
        end else if (step == 3'd1) begin
          set_lines(1'b1, 1'b0, 1'b1);
          step = 3'd2;
        end else begin
          set_lines(1'b1, 1'b1, 1'b1);
          fin = 1'b1;
          enter(BUS_IDLE);
        end
      end
      default: enter(BUS_IDLE);
    endcase
  endfunction

  // Applies one accepted word to the model and returns the result word it should cause.
  function automatic line_report_t line_report_for(input logic [1:0] code,
                                                   input logic [7:0] reg_addr,
                                                   input logic [15:0] count,
                                                   input logic [7:0] data,
                                                   input logic sda);
    line_report_t r;
    logic rv, nack, fin;
    rv = 1'b0;
    nack = 1'b0;
    fin = 1'b0;
    if (code == OP_PUSH) begin
      if (fill < QDEPTH) begin
        queue_mem[QAW'(rd_ptr + fill)] = data;
        fill = fill + 1'b1;
      end
    end else if (code == OP_READ || code == OP_WRITE) begin
      if (ph == BUS_IDLE) begin
        reg_hold = reg_addr;
        remaining = count;
        reading = (code == OP_READ);
        enter(BUS_START);
      end
    end else if (ph != BUS_IDLE) begin
      bus_step(sda, rv, nack, fin);
    end
    r.scl = line_scl;
    r.sda = line_sda;
    r.drv = line_drv;
    r.rbyte = rv ? shreg : 8'h00;
    r.rvalid = rv;
    r.nack = nack;
    r.busy = (ph != BUS_IDLE);
    r.fin = fin;
    return r;
  endfunction

  function automatic string show(input line_report_t r);
    return $sformatf("scl=%b sda=%b drv=%b byte=%h rvalid=%b nack=%b busy=%b done=%b",
                     r.scl, r.sda, r.drv, r.rbyte, r.rvalid, r.nack, r.busy, r.fin);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_model();
      awaited.delete();
    end else begin
      // Results leave before the word accepted at this edge is predicted.
      if (out_valid && out_ready) begin
        got = '{scl_level, sda_level, sda_driving, read_byte, read_valid, nack_seen,
                busy_res, done_res};
        if (awaited.size() == 0) begin
          errs++;
          if (errs <= 10) $display("Unexpected result word: %s", show(got));
        end else begin
          want = awaited.pop_front();
          if (got !== want) begin
            errs++;
            if (errs <= 10) begin
              $display("Result mismatch at %0t", $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
      // A word accepted at the same edge as an address write still sees the old address.
      if (in_valid && in_ready)
        awaited.push_back(line_report_for(op, target_reg, byte_count, write_byte, sda_in));
      if (cfg_wen) dev_addr = cfg_wdata;
    end
    pending <= awaited.size();
    fail_count <= errs;
  end

endmodule

>>> tb/i2c_master_register_access_top_test.sv
module i2c_master_register_access_top_test;
  import i2cm_pkg::*;

  localparam int QDEPTH = FIFO_DEPTH_DEF;
  // Far above the slowest legal run: every word waiting out a full sender gap and
  // a full receiver stall, plus the long receiver hold and the address changes.
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen;
  logic [6:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  op;
  logic [7:0]  target_reg;
  logic [15:0] byte_count;
  logic [7:0]  write_byte;
  logic        sda_in;
  logic        out_valid;
  logic        out_ready;
  logic        scl_level;
  logic        sda_level;
  logic        sda_driving;
  logic [7:0]  read_byte;
  logic        read_valid;
  logic        nack_seen;
  logic        busy_res;
  logic        done_res;

  int fail_count;
  int pending;

  // Bookkeeping on the stimulus side. The queue fill is known exactly because
  // every transaction is run to completion before the next one starts.
  int  queued;
  int  useful;
  int  words_sent;
  int  reads, writes, bytes_in, bytes_out;
  int  cycles;
  bit  quiet;
  bit  sender_gaps;
  bit  hold_go;

  i2c_master_register_access_top uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_wen          (cfg_wen),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .op               (op),
    .target_reg       (target_reg),
    .byte_count       (byte_count),
    .write_byte       (write_byte),
    .sda_in           (sda_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .scl_level        (scl_level),
    .sda_level        (sda_level),
    .sda_driving      (sda_driving),
    .read_byte        (read_byte),
    .read_valid       (read_valid),
    .nack_seen        (nack_seen),
    .busy_res         (busy_res),
    .done_res         (done_res)
  );

  // The checker watches both channels and the configuration port, predicts every
  // result word and compares. This module only drives stimulus and reports.
  i2c_master_register_access_checker bus_check (
    .clk              (clk),
    .rst              (rst),
    .cfg_wen          (cfg_wen),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .op               (op),
    .target_reg       (target_reg),
    .byte_count       (byte_count),
    .write_byte       (write_byte),
    .sda_in           (sda_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .scl_level        (scl_level),
    .sda_level        (sda_level),
    .sda_driving      (sda_driving),
    .read_byte        (read_byte),
    .read_valid       (read_valid),
    .nack_seen        (nack_seen),
    .busy_res         (busy_res),
    .done_res         (done_res),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog. A run that has not finished by the limit is a failure.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL i2c_master_register_access_top");
    $finish;
  end

  // Receiver side. Ready drops in random bursts, with stretches where it stays
  // high. Once the stimulus raises hold_go, ready is held low for HOLD_CYCLES so
  // that the result register fills and the input channel has to stall. In the
  // last part of the run ready stays high.
  initial begin : receiver
    int  stretch;
    bit  stalls_on;
    bit  held;
    stretch = 100;
    stalls_on = 1'b1;
    held = 1'b0;
    out_ready = 1'b1;
    forever begin
      if (hold_go && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
      stretch--;
      if (stretch <= 0) begin
        stalls_on = 1'($urandom_range(0, 1));
        stretch = $urandom_range(40, 200);
      end
    end
  end

  // Offers one word and returns at the edge where it is accepted. A random gap
  // may come first. Valid stays high across back-to-back words, so at the
  // accepting edge only the payload is updated. The tally flag is clear for
  // some of the words that the master ignores.
  task automatic send_word(input logic [1:0] code, input logic [7:0] reg_addr,
                           input logic [15:0] count, input logic [7:0] data,
                           input bit tally);
    int gap;
    gap = 0;
    if (!quiet && sender_gaps && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    target_reg <= reg_addr;
    byte_count <= count;
    write_byte <= data;
    sda_in <= 1'($urandom_range(0, 1));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (tally) useful++;
  endtask

  // Sends n timing ticks with random SDA levels, so acknowledge slots see both
  // ACK and NACK and read bytes carry random data. With poke set, a begin may
  // land somewhere inside the run while the master is busy; it must be ignored.
  task automatic bus_ticks(input int n, input bit poke);
    int at;
    at = -1;
    if (poke && n > 0 && $urandom_range(0, 2) == 0) at = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      if (i == at)
        send_word($urandom_range(0, 1) ? OP_READ : OP_WRITE, 8'($urandom), 16'($urandom),
                  8'($urandom), 1'b0);
      send_word(OP_TICK, 8'($urandom), 16'($urandom), 8'($urandom), 1'b1);
    end
  endtask

  task automatic push_byte(input logic [7:0] data);
    send_word(OP_PUSH, 8'($urandom), 16'($urandom), data, 1'b1);
  endtask

  // A register write of n data bytes. Bytes already queued are used first and
  // the rest are pushed before the begin. With hold_last the final byte is kept
  // back: the master stalls on its setup step with SCL low until the byte is
  // pushed after the full tick budget, and then needs 22 more ticks
  // (setup, eight bits, acknowledge, stop).
  task automatic run_write(input logic [7:0] reg_addr, input int n, input bit hold_last);
    int need, pre;
    need = (n > queued) ? n - queued : 0;
    pre = (hold_last && need > 0) ? need - 1 : need;
    for (int i = 0; i < pre; i++) push_byte(8'($urandom));
    send_word(OP_WRITE, reg_addr, 16'(n), 8'($urandom), 1'b1);
    // Start, two address bytes with their acknowledges, then each data byte
    // with its acknowledge, then stop.
    bus_ticks(44 + 19 * n, 1'b1);
    if (pre != need) begin
      push_byte(8'($urandom));
      bus_ticks(22, 1'b0);
    end
    bus_ticks($urandom_range(0, 3), 1'b0);
    queued = (need > 0) ? 0 : queued - n;
    writes++;
    bytes_out += n;
  endtask

  // A register read of n bytes: start, address and register, repeated start,
  // address with read bit, then 17 ticks per byte plus 4 for the master's
  // ACK or NACK. A zero count still sends the NACK before stop.
  task automatic run_read(input logic [7:0] reg_addr, input int n);
    send_word(OP_READ, reg_addr, 16'(n), 8'($urandom), 1'b1);
    bus_ticks(66 + ((n > 0) ? 21 * n : 4), 1'b1);
    bus_ticks($urandom_range(0, 3), 1'b0);
    reads++;
    bytes_in += n;
  endtask

  // Loads the device address once every result word has come back, so the
  // master is idle when the register changes.
  task automatic set_address(input logic [6:0] addr);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Mostly complete transactions with random counts and addresses; the rest is
  // extra pushes (which may overflow the queue) and ticks while idle.
  task automatic random_phase(input int amount);
    int stop_at, kind, n, k;
    stop_at = useful + amount;
    while (useful < stop_at) begin
      sender_gaps = 1'($urandom_range(0, 1));
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
        run_write(8'($urandom), n, $urandom_range(0, 3) == 0);
      end else if (kind < 8) begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
        run_read(8'($urandom), n);
      end else if (kind == 8) begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) push_byte(8'($urandom));
        queued = (queued + k > QDEPTH) ? QDEPTH : queued + k;
      end else begin
        repeat ($urandom_range(1, 4))
          send_word(OP_TICK, 8'($urandom), 16'($urandom), 8'($urandom), 1'b0);
      end
    end
  endtask

  initial begin : stimulus
    cfg_wen = 1'b0;
    cfg_wdata = 7'd0;
    in_valid = 1'b0;
    op = OP_TICK;
    target_reg = 8'd0;
    byte_count = 16'd0;
    write_byte = 8'd0;
    sda_in = 1'b1;
    queued = 0;
    useful = 0;
    words_sent = 0;
    reads = 0;
    writes = 0;
    bytes_in = 0;
    bytes_out = 0;
    quiet = 1'b0;
    sender_gaps = 1'b1;
    hold_go = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Highest device address first.
    set_address(7'h7F);

    // Zero-count write, a one-byte read, then a write that runs the empty queue
    // dry and has to wait for its last byte.
    run_write(8'hFF, 0, 1'b0);
    run_read(8'h80, 1);
    run_write(8'hC3, 2, 1'b1);

    // Fill the write queue with one byte too many; the last push is dropped.
    // All-zero and all-one data bytes go in first. Writes in the random part
    // send these bytes out ahead of any byte pushed later.
    for (int i = 0; i <= QDEPTH; i++)
      push_byte((i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom));
    queued = QDEPTH;

    // Zero-count read: no data bytes, but still NACK and stop. A begin with
    // all-ones fields and a push into the full queue arrive while it runs;
    // both must leave the master untouched.
    send_word(OP_READ, 8'h00, 16'h0000, 8'h00, 1'b1);
    bus_ticks(10, 1'b0);
    send_word(OP_WRITE, 8'hFF, 16'hFFFF, 8'hFF, 1'b0);
    send_word(OP_PUSH, 8'hFF, 16'hFFFF, 8'hA5, 1'b0);
    bus_ticks(66 + 4 - 10 + 2, 1'b0);
    reads++;

    // Random part in four address settings, lowest address among them.
    set_address(7'h00);
    random_phase(100);

    set_address(7'($urandom_range(1, 126)));
    hold_go = 1'b1;
    random_phase(100);

    set_address(7'($urandom));
    random_phase(100);

    // Last stretch runs flat out on both sides.
    quiet = 1'b1;
    set_address(7'($urandom));
    random_phase(90);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Drove %0d words: %0d register reads fetching %0d bytes, %0d writes sending %0d.",
             words_sent, reads, bytes_in, writes, bytes_out);
    $display("Five device addresses, queue overflow, empty-queue stalls, ignored begins, %0d-%s",
             HOLD_CYCLES, "cycle receiver hold.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS i2c_master_register_access_top");
    end else begin
      $display("FAIL i2c_master_register_access_top");
    end
    $finish;
  end

endmodule
